// File: hdl/assert_macros.svh
// Shared assertion macros. Both expect clk in scope; BRM_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define BRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define BRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/brm_pkg.sv
package brm_pkg;

  localparam int FIELD_W   = 32;
  localparam int PRODUCT_W = 64;

  // {multiplier lsb, previous bit}
  typedef logic [1:0] booth_pair_t;

  localparam booth_pair_t BOOTH_ADD = 2'b01;
  localparam booth_pair_t BOOTH_SUB = 2'b10;

endpackage

// File: hdl/brm_booth_stage.sv
`include "assert_macros.svh"

module brm_booth_stage #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W:0]   in_a,
  input  logic [W-1:0] in_q,
  input  logic [W:0]   in_m,
  input  logic         in_prev,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W:0]   out_a,
  output logic [W-1:0] out_q,
  output logic [W:0]   out_m,
  output logic         out_prev
);

  brm_pkg::booth_pair_t pair;
  logic [W:0]   sum;
  logic [W:0]   a_nxt;
  logic [W-1:0] q_nxt;
  logic         valid_r;
  logic [W:0]   a_r;
  logic [W-1:0] q_r;
  logic [W:0]   m_r;
  logic         prev_r;

  assign pair = {in_q[0], in_prev};

  always_comb begin
    case (pair)
      brm_pkg::BOOTH_SUB: sum = in_a - in_m;
      brm_pkg::BOOTH_ADD: sum = in_a + in_m;
      default:            sum = in_a;
    endcase
  end

  // arithmetic shift right of {a, q} as one word
  assign a_nxt = {sum[W], sum[W:1]};
  assign q_nxt = {sum[0], in_q[W-1:1]};

  // bubbles collapse: an empty stage always takes an item
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_r    <= a_nxt;
      q_r    <= q_nxt;
      m_r    <= in_m;
      prev_r <= in_q[0];
    end
  end

  assign out_valid = valid_r;
  assign out_a     = a_r;
  assign out_q     = q_r;
  assign out_m     = m_r;
  assign out_prev  = prev_r;

  `BRM_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !valid_r, "stage valid set after reset")
  `BRM_ASSERT(a_hold, valid_r && !out_ready |=> valid_r && $stable(a_r) && $stable(q_r),
              "stalled stage lost its item")
  `BRM_ASSERT(a_load, in_valid && in_ready |=> valid_r && prev_r == $past(in_q[0]),
              "accepted item not captured")

endmodule

// File: hdl/booth_radix2_multiplier.sv
// Signed radix-2 Booth multiplier, one Booth step per pipeline stage. Operands
// are the low OPERAND_WIDTH bits of each input field, taken as signed; the
// product is exact (the accumulator is one bit wider than the operands) and
// is sign-extended to 64 bits. An accepted item passes through every stage to
// its result; a new item can be taken every cycle while in_stall is low. The
// stage chain is elastic: empty stages fill while the output is stalled, so
// in_stall only rises once every stage holds an item and out_stall is high.
`include "assert_macros.svh"

module booth_radix2_multiplier #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [brm_pkg::FIELD_W-1:0]   in_multiplier_in,
  input  logic signed [brm_pkg::FIELD_W-1:0]   in_multiplicand_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [brm_pkg::PRODUCT_W-1:0] out_product_out
);

  localparam int W  = OPERAND_WIDTH;
  localparam int FW = 2 * OPERAND_WIDTH + 1;
  localparam int PW = brm_pkg::PRODUCT_W;

  logic [W:0]   a_s     [0:W];
  logic [W-1:0] q_s     [0:W];
  logic [W:0]   m_s     [0:W];
  logic         prev_s  [0:W];
  logic         valid_s [0:W];
  logic         ready_s [0:W];
  logic [FW-1:0] full;

  assign a_s[0]     = '0;
  assign q_s[0]     = in_multiplier_in[W-1:0];
  assign m_s[0]     = {in_multiplicand_in[W-1], in_multiplicand_in[W-1:0]};
  assign prev_s[0]  = 1'b0;
  assign valid_s[0] = in_valid;
  assign in_stall   = !ready_s[0];

  for (genvar i = 0; i < W; i++) begin : g_step
    brm_booth_stage #(
      .W(W)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_s[i]),
      .in_ready (ready_s[i]),
      .in_a     (a_s[i]),
      .in_q     (q_s[i]),
      .in_m     (m_s[i]),
      .in_prev  (prev_s[i]),
      .out_valid(valid_s[i+1]),
      .out_ready(ready_s[i+1]),
      .out_a    (a_s[i+1]),
      .out_q    (q_s[i+1]),
      .out_m    (m_s[i+1]),
      .out_prev (prev_s[i+1])
    );
  end

  assign ready_s[W] = !out_stall;
  assign out_valid  = valid_s[W];

  assign full            = {a_s[W], q_s[W]};
  assign out_product_out = PW'($signed(full));

  `BRM_ASSERT(a_stall_src, in_stall |-> out_stall, "input stalled with output free")
  `BRM_ASSERT(a_full_stall, in_stall |-> out_valid, "input stalled with empty output")
  `BRM_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

// File: tb/sv/booth_radix2_multiplier_test.sv
module booth_radix2_multiplier_test;

  localparam int FIELD_W      = brm_pkg::FIELD_W;
  localparam int PRODUCT_W    = brm_pkg::PRODUCT_W;
  localparam int OP_W         = 32;
  localparam int LATENCY      = OP_W;
  localparam int RANDOM_ITEMS = 680;
  localparam int HOLD_CYCLES  = 120;
  localparam int QUIET_TAIL   = 80;

  typedef struct packed {
    logic [FIELD_W-1:0] multiplier;
    logic [FIELD_W-1:0] multiplicand;
  } operand_pair_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [FIELD_W-1:0]   in_multiplier_in;
  logic signed [FIELD_W-1:0]   in_multiplicand_in;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [PRODUCT_W-1:0] out_product_out;

  operand_pair_t               pending_pairs[$];
  operand_pair_t               next_pair;
  logic signed [PRODUCT_W-1:0] product_q[$];
  logic signed [PRODUCT_W-1:0] want_product;

  logic in_taken;
  int   errors;
  int   accepted_count;
  int   results_seen;
  int   in_stall_cycles;
  int   send_gap;
  int   stall_gap;
  int   hold_left;
  bit   hold_done;

  booth_radix2_multiplier #(
    .OPERAND_WIDTH(OP_W)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_multiplier_in  (in_multiplier_in),
    .in_multiplicand_in(in_multiplicand_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_product_out   (out_product_out)
  );

  always #5 clk = ~clk;

  // Operands are the low OP_W bits of each field, taken as signed
  function automatic logic signed [PRODUCT_W-1:0] signed_product(
    logic [FIELD_W-1:0] mlr, logic [FIELD_W-1:0] mcd);
    logic signed [PRODUCT_W-1:0] a;
    logic signed [PRODUCT_W-1:0] b;
    a = {{(PRODUCT_W-FIELD_W){1'b0}}, mlr};
    b = {{(PRODUCT_W-FIELD_W){1'b0}}, mcd};
    a = (a <<< (PRODUCT_W - OP_W)) >>> (PRODUCT_W - OP_W);
    b = (b <<< (PRODUCT_W - OP_W)) >>> (PRODUCT_W - OP_W);
    return a * b;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_operand();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = {1'b1, {(FIELD_W-1){1'b0}}};
      1:       v = {1'b0, {(FIELD_W-1){1'b1}}};
      2:       v = '1;
      3:       v = FIELD_W'(1) << $urandom_range(0, FIELD_W-1);
      4, 5:    v = FIELD_W'($urandom_range(0, 64)) - FIELD_W'(32);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // no idling in the tail, and every third block of 64 items runs flat out
  function automatic bit idle_allowed();
    return pending_pairs.size() > QUIET_TAIL && ((accepted_count / 64) % 3 != 2);
  endfunction

  task automatic add_pair(logic [FIELD_W-1:0] mlr, logic [FIELD_W-1:0] mcd);
    operand_pair_t p;
    p.multiplier   = mlr;
    p.multiplicand = mcd;
    pending_pairs.push_back(p);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        next_pair = pending_pairs.pop_front();
        in_multiplier_in   <= next_pair.multiplier;
        in_multiplicand_in <= next_pair.multiplicand;
        in_valid <= 1'b1;
      end
    end
  end

  // receiver; one long hold-off part way through fills the pipeline
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // accepted items feed the product store; results are checked against it
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_stall)
        in_stall_cycles++;
      if (in_valid && !in_stall) begin
        product_q.push_back(signed_product(in_multiplier_in, in_multiplicand_in));
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected product, expected none, actual %0d (%h)",
                   $time, out_product_out, out_product_out);
          errors++;
        end else begin
          want_product = product_q.pop_front();
          if (out_product_out !== want_product) begin
            $display("%0t: product mismatch, expected %0d (%h), actual %0d (%h)",
                     $time, want_product, want_product, out_product_out,
                     out_product_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_multiplier_in   = '0;
    in_multiplicand_in = '0;
    out_stall          = 1'b0;
    in_taken           = 1'b0;
    errors             = 0;
    accepted_count     = 0;
    results_seen       = 0;
    in_stall_cycles    = 0;
    send_gap           = 0;
    stall_gap          = 0;
    hold_left          = 0;
    hold_done          = 1'b0;

    // corners: zero, unit, extremes, most negative multiplicand, bit patterns
    add_pair(32'h0000_0000, 32'h0000_0000);
    add_pair(32'h0000_0001, 32'h0000_0001);
    add_pair(32'hffff_ffff, 32'hffff_ffff);
    add_pair(32'h7fff_ffff, 32'h7fff_ffff);
    add_pair(32'h8000_0000, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h7fff_ffff);
    add_pair(32'h7fff_ffff, 32'h8000_0000);
    add_pair(32'hffff_ffff, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'hffff_ffff);
    add_pair(32'h0000_0000, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h0000_0000);
    add_pair(32'h0000_0001, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h0000_0001);
    add_pair(32'h7fff_ffff, 32'hffff_ffff);
    add_pair(32'haaaa_aaaa, 32'h5555_5555);
    add_pair(32'h5555_5555, 32'haaaa_aaaa);
    add_pair(32'haaaa_aaaa, 32'h8000_0000);
    add_pair(32'h0000_0003, 32'hffff_fff9);
    add_pair(32'hffff_fff9, 32'h0000_0003);
    add_pair(32'h0f0f_0f0f, 32'hf0f0_f0f0);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      add_pair(pick_operand(), pick_operand());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_valid || product_q.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);

    $display("Covered %0d operand pairs (extremes, most negative multiplicand, random mix)",
             accepted_count);
    $display("%0d products checked; input held off for %0d cycles under output back-pressure",
             results_seen, in_stall_cycles);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d products still outstanding", $time, product_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
